// ----- hw/rtl/target_tracking_pid_assert.svh -----
// Assertion macros used by the tracker top level.
`ifndef TARGET_TRACKING_PID_ASSERT_SVH
`define TARGET_TRACKING_PID_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ttp_pkg.sv -----
// Types, codes, constants and the arctangent table of the target tracker.
package ttp_pkg;

    // Request operation codes.
    localparam logic [2:0] OP_DETECT = 3'd0;
    localparam logic [2:0] OP_TICK   = 3'd1;
    localparam logic [2:0] OP_START  = 3'd2;
    localparam logic [2:0] OP_STOP   = 3'd3;
    localparam logic [2:0] OP_TOGGLE = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_NOT_FOUND = 2'd0;
    localparam logic [1:0] ST_WAITING   = 2'd1;
    localparam logic [1:0] ST_FOUND     = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [2:0] CFG_INTEG_GAIN = 3'd1;
    localparam logic [2:0] CFG_DERIV_GAIN = 3'd2;
    localparam logic [2:0] CFG_LOST_LIMIT = 3'd3;
    localparam logic [2:0] CFG_WAIT_LIMIT = 3'd4;
    localparam logic [2:0] CFG_SCAN_EN    = 3'd5;
    localparam logic [2:0] CFG_PAN_FOV    = 3'd6;
    localparam logic [2:0] CFG_TILT_FOV   = 3'd7;

    // Arithmetic constants.
    localparam int CORDIC_STEPS   = 20;
    localparam int DERIV_SCALE    = 1000000;
    localparam int DERIV_SCALE_W  = 20;
    localparam int GAIN_W         = 16;
    localparam int MIN_MOVE_ANGLE = 71;
    localparam logic signed [23:0] CMD_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] CMD_MIN = 24'sh800000;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [15:0] ball_x;
        logic signed [15:0] ball_y;
        logic [15:0]        target_size;
        logic [31:0]        timestamp;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [23:0] pan_command;
        logic signed [23:0] tilt_command;
        logic               move_valid;
        logic               scan_request;
        logic               go_home;
    } t_out;

    typedef struct packed {
        logic signed [15:0] prop;
        logic signed [15:0] integ;
        logic signed [15:0] deriv;
    } t_gains;

    typedef struct packed {
        logic signed [15:0] err;
        logic signed [23:0] sum;
        logic signed [23:0] cmd;
    } t_axis_res;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_RUN,
        CS_DONE
    } t_ctl_state;

    typedef enum logic [2:0] {
        AS_IDLE,
        AS_ATAN_GO,
        AS_ATAN,
        AS_ERR,
        AS_DIV,
        AS_DER,
        AS_MAC,
        AS_FIN
    } t_axis_state;

    // Arctangent of 2^-i in Q24 radians.
    function automatic logic [23:0] atan_entry(input logic [4:0] idx);
        logic [23:0] v;
        case (idx)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/ttp_cordic.sv -----
// Iterative CORDIC arctangent, one rotation step per cycle.
module ttp_cordic (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [29:0] i_arg,
    output logic        o_done,
    output logic [13:0] o_angle
);
    import ttp_pkg::*;

    logic signed [32:0] r_x;
    logic signed [32:0] r_y;
    logic signed [26:0] r_z;
    logic [4:0]         r_step;
    logic               r_busy;
    logic               r_done;
    logic               r_zero;

    logic signed [32:0] w_xs;
    logic signed [32:0] w_ys;
    logic signed [26:0] w_tab;
    logic signed [26:0] w_zrnd;

    // Shifted operands and table angle for the current step.
    always_comb begin
        w_xs   = r_x >>> r_step;
        w_ys   = r_y >>> r_step;
        w_tab  = signed'({3'b000, atan_entry(r_step)});
        w_zrnd = r_z + 27'sd2048;
    end

    // Control: a run of CORDIC_STEPS steps, then a one-cycle done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == 5'(CORDIC_STEPS - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Vectoring rotations drive y toward zero while z collects the angle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= 33'sh0_0800_0000;
            r_y    <= signed'({3'b000, i_arg});
            r_z    <= '0;
            r_step <= '0;
            r_zero <= (i_arg == '0);
        end else if (r_busy) begin
            if (!r_y[32]) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_tab;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_tab;
            end
            r_step <= r_step + 5'd1;
        end
    end

    // Round to Q12; a zero argument or a negative angle reads as zero.
    assign o_done  = r_done;
    assign o_angle = (r_zero || r_z[26]) ? 14'd0 : w_zrnd[25:12];

endmodule

// ----- hw/rtl/ttp_axis.sv -----
// One axis of the tracker: angle error, serial divide for the derivative, serial PID MAC.
module ttp_axis (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [15:0]    i_pos,
    input  logic [14:0]           i_tangent,
    input  logic signed [15:0]    i_prev_err,
    input  logic signed [23:0]    i_sum,
    input  logic [31:0]           i_dt,
    input  ttp_pkg::t_gains       i_gains,
    output logic                  o_done,
    output ttp_pkg::t_axis_res    o_res
);
    import ttp_pkg::*;

    localparam int MAG_W = 14;
    localparam int NUM_W = MAG_W + DERIV_SCALE_W;
    localparam int ACC_W = 42;
    localparam logic signed [ACC_W-1:0] ACC_MAX = 42'sd8388607;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -42'sd8388608;

    t_axis_state r_state;
    t_axis_state n_state;

    logic [29:0]              r_mag;
    logic                     r_tneg;
    logic signed [15:0]       r_prev;
    logic signed [23:0]       r_sum;
    logic [31:0]              r_dt;
    logic                     r_dt_nz;
    t_gains                   r_gains;
    logic signed [15:0]       r_err;
    logic                     r_dneg;
    logic                     r_dnz;
    logic [NUM_W-1:0]         r_num;
    logic [31:0]              r_rem;
    logic [5:0]               r_cnt;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_op_err;
    logic signed [ACC_W-1:0]  r_op_der;
    logic signed [ACC_W-1:0]  r_op_sum;
    logic [GAIN_W-1:0]        r_gp;
    logic [GAIN_W-1:0]        r_gi;
    logic [GAIN_W-1:0]        r_gd;

    logic                     w_cordic_start;
    logic                     w_cordic_done;
    logic [13:0]              w_angle;
    logic signed [31:0]       w_prod;
    logic signed [15:0]       w_ang16;
    logic signed [16:0]       w_diff;
    logic signed [16:0]       w_dabs;
    logic signed [24:0]       w_sum_ext;
    logic signed [23:0]       w_sum_sat;
    logic [32:0]              w_rem_sh;
    logic [32:0]              w_rem_sub;
    logic                     w_ge;
    logic signed [23:0]       w_der;
    logic signed [ACC_W-1:0]  w_pp;
    logic                     w_mac_last;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [ACC_W-1:0]  w_shr;
    logic signed [23:0]       w_cmd;

    ttp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cordic_start),
        .i_arg   (r_mag),
        .o_done  (w_cordic_done),
        .o_angle (w_angle)
    );

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state and strobes.
    always_comb begin
        n_state        = r_state;
        w_cordic_start = 1'b0;
        o_done         = 1'b0;
        case (r_state)
            AS_IDLE: begin
                if (i_start) begin
                    n_state = AS_ATAN_GO;
                end
            end
            AS_ATAN_GO: begin
                w_cordic_start = 1'b1;
                n_state        = AS_ATAN;
            end
            AS_ATAN: begin
                if (w_cordic_done) begin
                    n_state = AS_ERR;
                end
            end
            AS_ERR: begin
                n_state = AS_DIV;
            end
            AS_DIV: begin
                if (r_cnt == 6'(NUM_W - 1)) begin
                    n_state = AS_DER;
                end
            end
            AS_DER: begin
                n_state = AS_MAC;
            end
            AS_MAC: begin
                if (w_mac_last) begin
                    n_state = AS_FIN;
                end
            end
            AS_FIN: begin
                o_done  = 1'b1;
                n_state = AS_IDLE;
            end
            default: begin
                n_state = AS_IDLE;
            end
        endcase
    end

    // Position times field-of-view tangent, and the signed angle error.
    always_comb begin
        w_prod  = i_pos * signed'({1'b0, i_tangent});
        w_ang16 = signed'({2'b00, w_angle});
        w_diff  = 17'(r_err) - 17'(r_prev);
        w_dabs  = w_diff[16] ? -w_diff : w_diff;
    end

    // Saturating integral update.
    always_comb begin
        w_sum_ext = 25'(r_sum) + 25'(r_err);
        if (w_sum_ext > 25'sd8388607) begin
            w_sum_sat = CMD_MAX;
        end else if (w_sum_ext < -25'sd8388608) begin
            w_sum_sat = CMD_MIN;
        end else begin
            w_sum_sat = w_sum_ext[23:0];
        end
    end

    // One restoring division step: a quotient bit per cycle.
    always_comb begin
        w_rem_sh  = {r_rem, r_num[NUM_W-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_dt});
        w_rem_sub = w_rem_sh - {1'b0, r_dt};
    end

    // Derivative from the quotient: sign, saturation, and the zero-interval case.
    always_comb begin
        if (!r_dt_nz) begin
            if (!r_dnz) begin
                w_der = '0;
            end else begin
                w_der = r_dneg ? CMD_MIN : CMD_MAX;
            end
        end else if (r_dneg) begin
            w_der = (r_num > NUM_W'(8388608)) ? CMD_MIN : -signed'(r_num[23:0]);
        end else begin
            w_der = (r_num > NUM_W'(8388607)) ? CMD_MAX : signed'(r_num[23:0]);
        end
    end

    // Partial products for one gain bit; the top bit carries negative weight.
    always_comb begin
        w_mac_last = (r_cnt == 6'(GAIN_W - 1));
        w_pp = (r_gp[0] ? r_op_err : '0) + (r_gd[0] ? r_op_der : '0)
             + (r_gi[0] ? r_op_sum : '0);
    end

    // Round to Q12 and saturate the command.
    always_comb begin
        w_rnd = r_acc + 42'sd2048;
        w_shr = w_rnd >>> 12;
        if (w_shr > ACC_MAX) begin
            w_cmd = CMD_MAX;
        end else if (w_shr < ACC_MIN) begin
            w_cmd = CMD_MIN;
        end else begin
            w_cmd = w_shr[23:0];
        end
    end

    // Datapath registers, advanced by the sequencer state.
    always_ff @(posedge i_clk) begin
        case (r_state)
            AS_IDLE: begin
                if (i_start) begin
                    r_mag   <= w_prod[31] ? 30'(-w_prod) : w_prod[29:0];
                    r_tneg  <= w_prod[31];
                    r_prev  <= i_prev_err;
                    r_sum   <= i_sum;
                    r_dt    <= i_dt;
                    r_dt_nz <= (i_dt != '0);
                    r_gains <= i_gains;
                end
            end
            AS_ATAN: begin
                if (w_cordic_done) begin
                    r_err <= r_tneg ? w_ang16 : -w_ang16;
                end
            end
            AS_ERR: begin
                r_num  <= NUM_W'(w_dabs[MAG_W-1:0]) * NUM_W'(DERIV_SCALE);
                r_rem  <= '0;
                r_cnt  <= '0;
                r_dneg <= w_diff[16];
                r_dnz  <= (w_diff != '0);
                r_sum  <= w_sum_sat;
            end
            AS_DIV: begin
                r_rem <= w_ge ? w_rem_sub[31:0] : w_rem_sh[31:0];
                r_num <= {r_num[NUM_W-2:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
            end
            AS_DER: begin
                r_op_err <= ACC_W'(r_err);
                r_op_der <= ACC_W'(w_der);
                r_op_sum <= ACC_W'(r_sum);
                r_gp     <= r_gains.prop;
                r_gi     <= r_gains.integ;
                r_gd     <= r_gains.deriv;
                r_acc    <= '0;
                r_cnt    <= '0;
            end
            AS_MAC: begin
                r_acc    <= w_mac_last ? (r_acc - w_pp) : (r_acc + w_pp);
                r_op_err <= r_op_err <<< 1;
                r_op_der <= r_op_der <<< 1;
                r_op_sum <= r_op_sum <<< 1;
                r_gp     <= r_gp >> 1;
                r_gi     <= r_gi >> 1;
                r_gd     <= r_gd >> 1;
                r_cnt    <= r_cnt + 6'd1;
            end
            default: begin
            end
        endcase
    end

    assign o_res.err = r_err;
    assign o_res.sum = r_sum;
    assign o_res.cmd = w_cmd;

endmodule

// ----- hw/rtl/target_tracking_pid.sv -----
// Two-axis pan/tilt PID target tracker with lost-target handling.
//
// Requests enter on the input channel (i_in_valid, o_in_stall, i_in_data) and
// every request yields exactly one result on the output channel (o_out_valid,
// i_out_stall, o_out_data). A request is taken at a clock edge with valid high
// and stall low. The block works on one request at a time.
// Detections, start, stop, toggle and ticks that need no axis computation pass
// through the EXEC and DONE states, and DONE loads the result register. A tick
// with a held target while tracking also passes through RUN: per axis, in
// parallel, 20 CORDIC steps and a done strobe for the arctangent, a
// one-bit-per-cycle divider over a 34-bit dividend for the derivative, a
// one-gain-bit-per-cycle multiply-accumulate over 16 gain bits, and sequencing.
// The result register frees the input side: a new request is taken while the
// previous result still waits; a stalled result stays put, and a finished
// request waits in the block until the result register is free.
// Configuration registers are written through i_cfg_we/i_cfg_index/i_cfg_data
// while the block is idle; the user is bound to this, the block does not
// enforce it. Reset (i_rst_n low, synchronous) holds the input stalled, restores
// the register defaults, stops tracking and clears the tracker state.
`include "target_tracking_pid_assert.svh"

module target_tracking_pid (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ttp_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ttp_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);
    import ttp_pkg::*;

    localparam logic signed [23:0] MOVE_LIM = 24'(MIN_MOVE_ANGLE);

    t_ctl_state r_state;
    t_ctl_state n_state;

    // Configuration registers.
    logic signed [15:0] r_prop_gain;
    logic signed [15:0] r_integ_gain;
    logic signed [15:0] r_deriv_gain;
    logic [7:0]         r_lost_limit;
    logic [7:0]         r_wait_limit;
    logic               r_scan_enable;
    logic [14:0]        r_pan_fov;
    logic [14:0]        r_tilt_fov;

    // Tracker state.
    logic               r_tracking;
    logic [7:0]         r_miss;
    logic [1:0]         r_last_status;
    logic signed [15:0] r_prev_pan;
    logic signed [15:0] r_prev_tilt;
    logic signed [23:0] r_sum_pan;
    logic signed [23:0] r_sum_tilt;
    logic signed [15:0] r_held_x;
    logic signed [15:0] r_held_y;
    logic [15:0]        r_held_size;
    logic [31:0]        r_last_time;

    t_in                r_item;
    t_out               r_res;
    t_out               r_out;
    logic               r_out_valid;

    logic               w_in_acc;
    logic               w_axis_start;
    logic               w_load;
    logic               w_pan_done;
    logic               w_tilt_done;
    t_axis_res          w_pan_res;
    t_axis_res          w_tilt_res;
    t_gains             w_gains;
    logic [31:0]        w_dt;
    logic [7:0]         w_miss_inc;
    logic               w_wait;
    logic               w_lost;
    logic [7:0]         w_miss_after;
    logic [1:0]         w_miss_status;
    logic               w_tracked_tick;
    t_out               w_exec_res;
    t_out               w_run_res;

    assign o_in_stall = (r_state != CS_IDLE) || !i_rst_n;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_gains = '{prop: r_prop_gain, integ: r_integ_gain, deriv: r_deriv_gain};
    assign w_dt    = r_item.timestamp - r_last_time;

    ttp_axis u_pan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_axis_start),
        .i_pos      (r_held_x),
        .i_tangent  (r_pan_fov),
        .i_prev_err (r_prev_pan),
        .i_sum      (r_sum_pan),
        .i_dt       (w_dt),
        .i_gains    (w_gains),
        .o_done     (w_pan_done),
        .o_res      (w_pan_res)
    );

    ttp_axis u_tilt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_axis_start),
        .i_pos      (r_held_y),
        .i_tangent  (r_tilt_fov),
        .i_prev_err (r_prev_tilt),
        .i_sum      (r_sum_tilt),
        .i_dt       (w_dt),
        .i_gains    (w_gains),
        .o_done     (w_tilt_done),
        .o_res      (w_tilt_res)
    );

    // Miss counting on a tick without a held target.
    always_comb begin
        w_miss_inc   = (r_miss != 8'hFF) ? (r_miss + 8'd1) : r_miss;
        w_wait       = (w_miss_inc < r_wait_limit);
        w_lost       = !w_wait && (w_miss_inc > r_lost_limit);
        w_miss_after = w_lost ? 8'd0 : w_miss_inc;
        if (w_wait && ((r_last_status == ST_WAITING) || (r_last_status == ST_FOUND))) begin
            w_miss_status = ST_WAITING;
        end else begin
            w_miss_status = ST_NOT_FOUND;
        end
    end

    assign w_tracked_tick = (r_item.operation == OP_TICK) && r_tracking
                          && (r_held_size != '0);

    // Result of a request that needs no axis computation.
    always_comb begin
        w_exec_res        = '0;
        w_exec_res.status = r_last_status;
        case (r_item.operation)
            OP_STOP: begin
                w_exec_res.go_home = 1'b1;
            end
            OP_TOGGLE: begin
                w_exec_res.go_home = r_tracking;
            end
            OP_TICK: begin
                if (!r_tracking) begin
                    w_exec_res.status = ST_NOT_FOUND;
                end else if (r_held_size == '0) begin
                    w_exec_res.status       = w_miss_status;
                    w_exec_res.scan_request = w_lost && r_scan_enable;
                end
            end
            default: begin
            end
        endcase
    end

    // Result of a tracked tick.
    always_comb begin
        w_run_res              = '0;
        w_run_res.status       = ST_FOUND;
        w_run_res.pan_command  = w_pan_res.cmd;
        w_run_res.tilt_command = w_tilt_res.cmd;
        w_run_res.move_valid   = !((w_pan_res.cmd > -MOVE_LIM) && (w_pan_res.cmd < MOVE_LIM)
                               && (w_tilt_res.cmd > -MOVE_LIM) && (w_tilt_res.cmd < MOVE_LIM));
    end

    // Control state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control next state and strobes.
    always_comb begin
        n_state      = r_state;
        w_axis_start = 1'b0;
        w_load       = 1'b0;
        case (r_state)
            CS_IDLE: begin
                if (w_in_acc) begin
                    n_state = CS_EXEC;
                end
            end
            CS_EXEC: begin
                if (w_tracked_tick) begin
                    w_axis_start = 1'b1;
                    n_state      = CS_RUN;
                end else begin
                    n_state = CS_DONE;
                end
            end
            CS_RUN: begin
                if (w_pan_done) begin
                    n_state = CS_DONE;
                end
            end
            CS_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load  = 1'b1;
                    n_state = CS_IDLE;
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= 16'sd1638;
            r_integ_gain  <= '0;
            r_deriv_gain  <= '0;
            r_lost_limit  <= 8'd50;
            r_wait_limit  <= 8'd5;
            r_scan_enable <= 1'b1;
            r_pan_fov     <= 15'd2889;
            r_tilt_fov    <= 15'd1622;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:  r_prop_gain   <= i_cfg_data;
                CFG_INTEG_GAIN: r_integ_gain  <= i_cfg_data;
                CFG_DERIV_GAIN: r_deriv_gain  <= i_cfg_data;
                CFG_LOST_LIMIT: r_lost_limit  <= i_cfg_data[7:0];
                CFG_WAIT_LIMIT: r_wait_limit  <= i_cfg_data[7:0];
                CFG_SCAN_EN:    r_scan_enable <= i_cfg_data[0];
                CFG_PAN_FOV:    r_pan_fov     <= i_cfg_data[14:0];
                CFG_TILT_FOV:   r_tilt_fov    <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    // Tracker state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking    <= 1'b0;
            r_miss        <= '0;
            r_last_status <= ST_NOT_FOUND;
            r_prev_pan    <= '0;
            r_prev_tilt   <= '0;
            r_sum_pan     <= '0;
            r_sum_tilt    <= '0;
            r_held_x      <= '0;
            r_held_y      <= '0;
            r_held_size   <= '0;
            r_last_time   <= '0;
        end else begin
            case (r_state)
                CS_EXEC: begin
                    case (r_item.operation)
                        OP_DETECT: begin
                            if (r_item.target_size > r_held_size) begin
                                r_held_x    <= r_item.ball_x;
                                r_held_y    <= r_item.ball_y;
                                r_held_size <= r_item.target_size;
                            end
                        end
                        OP_START: begin
                            r_tracking <= 1'b1;
                        end
                        OP_STOP: begin
                            r_tracking  <= 1'b0;
                            r_prev_pan  <= '0;
                            r_prev_tilt <= '0;
                            r_sum_pan   <= '0;
                            r_sum_tilt  <= '0;
                        end
                        OP_TOGGLE: begin
                            r_tracking <= !r_tracking;
                            if (r_tracking) begin
                                r_prev_pan  <= '0;
                                r_prev_tilt <= '0;
                                r_sum_pan   <= '0;
                                r_sum_tilt  <= '0;
                            end
                        end
                        OP_TICK: begin
                            if (!r_tracking) begin
                                r_held_size <= '0;
                                r_miss      <= '0;
                            end else if (r_held_size == '0) begin
                                r_miss        <= w_miss_after;
                                r_last_status <= w_miss_status;
                                if (w_miss_status == ST_NOT_FOUND) begin
                                    r_prev_pan  <= '0;
                                    r_prev_tilt <= '0;
                                    r_sum_pan   <= '0;
                                    r_sum_tilt  <= '0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                CS_RUN: begin
                    if (w_pan_done) begin
                        r_miss        <= '0;
                        r_last_time   <= r_item.timestamp;
                        r_sum_pan     <= w_pan_res.sum;
                        r_sum_tilt    <= w_tilt_res.sum;
                        r_prev_pan    <= w_pan_res.err;
                        r_prev_tilt   <= w_tilt_res.err;
                        r_held_size   <= '0;
                        r_last_status <= ST_FOUND;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Request capture and result staging.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= i_in_data;
        end
        if (r_state == CS_EXEC) begin
            r_res <= w_exec_res;
        end else if ((r_state == CS_RUN) && w_pan_done) begin
            r_res <= w_run_res;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `TTP_ASSERT_IMP(a_axes_lockstep, i_clk, i_rst_n, 1'b1, w_pan_done == w_tilt_done, "axes finished apart")
    `TTP_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, w_in_acc, r_state == CS_EXEC, "request not started")
    `TTP_ASSERT_IMP(a_run_tracking, i_clk, i_rst_n, r_state == CS_RUN, r_tracking, "run without tracking")
    `TTP_ASSERT_IMP(a_scan_lost, i_clk, i_rst_n, r_out_valid && r_out.scan_request, r_out.status == ST_NOT_FOUND, "scan while found")
    `TTP_ASSERT_IMP(a_move_found, i_clk, i_rst_n, r_out_valid && r_out.move_valid, r_out.status == ST_FOUND, "move without target")

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the target tracker with random and directed requests.
`timescale 1ns / 100ps

module testbench;
    import ttp_pkg::*;

    // Operation codes the block does not define, and the size that marks a pause.
    localparam logic [2:0]  OP_UNDEF_LO = 3'd5;
    localparam logic [2:0]  OP_UNDEF_HI = 3'd7;
    localparam logic [31:0] MARK_SIZE   = 32'hDEAD;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       in_taken = 1'b0;
    t_in        in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b1;
    t_out       out_data;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = CFG_PROP_GAIN;
    logic [15:0] cfg_data = '0;

    target_tracking_pid dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Tracker state mirrored for prediction.
    logic signed [15:0] g_prop, g_integ, g_deriv;
    logic [7:0]         lim_lost, lim_wait;
    logic               scan_on;
    logic [14:0]        tan_pan, tan_tilt;
    logic               trk_on;
    int unsigned        misses;
    logic [1:0]         prev_status;
    longint             prev_ep, prev_et, sum_p, sum_t, hx, hy;
    int unsigned        hsize;
    logic [31:0]        found_time;

    t_in  pending_reqs[$];
    t_out expected_results[$];
    int   n_errors = 0;
    int   hold_off = 0;

    function automatic longint clamp(longint v);
        return v < -8388608 ? -8388608 : (v > 8388607 ? 8388607 : v);
    endfunction

    function automatic longint shr(longint v, int n);
        return v >>> n;
    endfunction

    // CORDIC vectoring arctangent, Q27 in, Q12 out.
    function automatic longint arctan_q12(longint a);
        longint x, y, z, xs, ys;
        longint tbl[20] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                            262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                            1024, 512, 256, 128, 64, 32};
        x = 64'sd1 <<< 27; y = a; z = 0;
        if (a == 0) return 0;
        for (int i = 0; i < 20; i++) begin
            xs = shr(x, i); ys = shr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += tbl[i];
            end else begin
                x -= ys; y += xs; z -= tbl[i];
            end
        end
        if (z < 0) z = 0;
        return (z + 2048) >>> 12;
    endfunction

    function automatic longint angle_err(longint pos, logic [14:0] tg);
        longint t;
        t = pos * longint'({1'b0, tg});
        return t >= 0 ? -arctan_q12(t) : arctan_q12(-t);
    endfunction

    function automatic longint rate_of(longint d, logic [31:0] dt);
        if (dt == 0) return d > 0 ? 8388607 : (d < 0 ? -8388608 : 0);
        return clamp((d * 1000000) / longint'({1'b0, dt}));
    endfunction

    function automatic longint pid_cmd(longint e, longint dr, longint s);
        longint acc;
        acc = e * longint'(g_prop) + dr * longint'(g_deriv) + s * longint'(g_integ);
        return clamp(shr(acc + 2048, 12));
    endfunction

    task automatic clear_loop();
        prev_ep = 0; prev_et = 0; sum_p = 0; sum_t = 0;
    endtask

    task automatic reset_tracker();
        g_prop = 16'sd1638; g_integ = '0; g_deriv = '0;
        lim_lost = 8'd50; lim_wait = 8'd5; scan_on = 1'b1;
        tan_pan = 15'd2889; tan_tilt = 15'd1622;
        trk_on = 1'b0; misses = 0; prev_status = ST_NOT_FOUND;
        clear_loop(); hx = 0; hy = 0; hsize = 0; found_time = '0;
    endtask

    // Append a request to the tail of the pending queue.
    task automatic queue_req(input t_in r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // Work out the result of one accepted request.
    task automatic predict_tracker(input t_in r);
        t_out o;
        longint ep, et, p, t;
        logic [31:0] dt;
        o = '0;
        o.status = prev_status;
        if (r.operation == OP_DETECT) begin
            if (r.target_size > hsize) begin
                hx = r.ball_x; hy = r.ball_y; hsize = r.target_size;
            end
        end else if (r.operation == OP_START || (r.operation == OP_TOGGLE && !trk_on)) begin
            trk_on = 1'b1;
        end else if (r.operation == OP_STOP || r.operation == OP_TOGGLE) begin
            trk_on = 1'b0; clear_loop(); o.go_home = 1'b1;
        end else if (r.operation == OP_TICK) begin
            if (!trk_on) begin
                hsize = 0; misses = 0; o.status = ST_NOT_FOUND;
            end else if (hsize == 0) begin
                if (misses < 255) misses++;
                if (misses < lim_wait) begin
                    o.status = (prev_status == ST_WAITING || prev_status == ST_FOUND)
                               ? ST_WAITING : ST_NOT_FOUND;
                end else begin
                    if (misses > lim_lost) begin
                        o.scan_request = scan_on; misses = 0;
                    end
                    o.status = ST_NOT_FOUND;
                end
                if (o.status == ST_NOT_FOUND) clear_loop();
                prev_status = o.status;
            end else begin
                dt = r.timestamp - found_time;
                ep = angle_err(hx, tan_pan);
                et = angle_err(hy, tan_tilt);
                misses = 0; found_time = r.timestamp;
                sum_p = clamp(sum_p + ep); sum_t = clamp(sum_t + et);
                p = pid_cmd(ep, rate_of(ep - prev_ep, dt), sum_p);
                t = pid_cmd(et, rate_of(et - prev_et, dt), sum_t);
                o.pan_command = p[23:0]; o.tilt_command = t[23:0];
                o.move_valid = !(p > -MIN_MOVE_ANGLE && p < MIN_MOVE_ANGLE &&
                                 t > -MIN_MOVE_ANGLE && t < MIN_MOVE_ANGLE);
                prev_ep = ep; prev_et = et; hsize = 0;
                o.status = ST_FOUND; prev_status = ST_FOUND;
            end
        end
        expected_results.insert(expected_results.size(), o);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        n_errors++;
    endtask

    // Acceptance of the offered request, seen at the rising edge.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_valid && !in_stall;
    end

    // Driver: bursts of requests with random gaps.
    int burst = 0, gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_taken)) begin
            if (in_valid) predict_tracker(in_data);
            if (gap > 0) begin
                gap--;
                in_valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && pending_reqs[0].operation == OP_UNDEF_HI
                         && pending_reqs[0].target_size == MARK_SIZE[15:0]) begin
                // Marker entry: pause until every expected result has come.
                in_valid <= 1'b0;
                if (expected_results.size() == 0 && !in_valid) void'(pending_reqs.pop_front());
            end else if (pending_reqs.size() > 0) begin
                in_data <= pending_reqs.pop_front();
                in_valid <= 1'b1;
                if (burst == 0) begin
                    burst = $urandom_range(1, 20);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end else burst--;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with an occasional long hold-off.
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase++;
        if (hold_off > 0) begin
            hold_off--;
            out_stall <= 1'b1;
        end else if (stall_phase % 400 < 150) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(0, 3) == 0);
    end

    // Monitor: compare each result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out e;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                e = expected_results.pop_front();
                if (out_data.status != e.status) report_mismatch("status", out_data.status, e.status);
                if (out_data.pan_command != e.pan_command)
                    report_mismatch("pan_command", out_data.pan_command, e.pan_command);
                if (out_data.tilt_command != e.tilt_command)
                    report_mismatch("tilt_command", out_data.tilt_command, e.tilt_command);
                if (out_data.move_valid != e.move_valid)
                    report_mismatch("move_valid", out_data.move_valid, e.move_valid);
                if (out_data.scan_request != e.scan_request)
                    report_mismatch("scan_request", out_data.scan_request, e.scan_request);
                if (out_data.go_home != e.go_home)
                    report_mismatch("go_home", out_data.go_home, e.go_home);
            end
        end
    end

    function automatic t_in make_req(logic [2:0] op, logic [31:0] x, logic [31:0] y,
                                     logic [31:0] sz, logic [31:0] ts);
        t_in r;
        r.operation = op; r.ball_x = x[15:0]; r.ball_y = y[15:0];
        r.target_size = sz[15:0]; r.timestamp = ts;
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PROP_GAIN:  g_prop = val;
            CFG_INTEG_GAIN: g_integ = val;
            CFG_DERIV_GAIN: g_deriv = val;
            CFG_LOST_LIMIT: lim_lost = val[7:0];
            CFG_WAIT_LIMIT: lim_wait = val[7:0];
            CFG_SCAN_EN:    scan_on = val[0];
            CFG_PAN_FOV:    tan_pan = val[14:0];
            default:        tan_tilt = val[14:0];
        endcase
    endtask

    logic [31:0] clock_us = '0;

    // One tracking episode with random content and occasional noise.
    task automatic add_episode(input int ticks);
        for (int k = 0; k < ticks; k++) begin
            int nd;
            nd = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
            for (int d = 0; d < nd; d++)
                queue_req(make_req(OP_DETECT, $urandom, $urandom,
                    ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom, $urandom));
            clock_us += ($urandom_range(0, 15) == 0) ? 32'($urandom) : $urandom_range(0, 40000);
            queue_req(make_req(OP_TICK, $urandom, $urandom, $urandom, clock_us));
            if ($urandom_range(0, 40) == 0)
                queue_req(make_req(3'($urandom_range(2, 7)), $urandom, $urandom,
                                   $urandom, $urandom));
        end
    endtask

    initial begin
        #50_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        reset_tracker();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every operation, field extremes, lost target and zero delta.
        queue_req(make_req(OP_TICK, 0, 0, 0, 0));
        queue_req(make_req(OP_START, 0, 0, 0, 0));
        queue_req(make_req(OP_DETECT, 32'h7FFF, 32'h8000, 32'hFFFF, 0));
        queue_req(make_req(OP_DETECT, 0, 0, 1, 0));
        queue_req(make_req(OP_TICK, 0, 0, 0, 1000));
        queue_req(make_req(OP_DETECT, 32'h8000, 32'h7FFF, 32'h10, 0));
        queue_req(make_req(OP_TICK, 0, 0, 0, 1000));
        queue_req(make_req(OP_DETECT, 0, 0, 32'h10, 0));
        queue_req(make_req(OP_TICK, 0, 0, 0, 32'hFFFF_FFFF));
        for (int i = 0; i < 8; i++) queue_req(make_req(OP_TICK, 0, 0, 0, i));
        queue_req(make_req(OP_UNDEF_LO, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF));
        queue_req(make_req(OP_UNDEF_HI, 0, 0, 0, 0));
        queue_req(make_req(OP_TOGGLE, 0, 0, 0, 0));
        queue_req(make_req(OP_TOGGLE, 0, 0, 0, 0));
        queue_req(make_req(OP_STOP, 0, 0, 0, 0));
        wait_drained();

        // Phases over register settings, extremes included.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_INTEG_GAIN, 16'd200); write_reg(CFG_DERIV_GAIN, 16'd3);
                    write_reg(CFG_LOST_LIMIT, 16'd3); write_reg(CFG_WAIT_LIMIT, 16'd2);
                end
                1: begin
                    write_reg(CFG_PROP_GAIN, 16'h7FFF); write_reg(CFG_INTEG_GAIN, 16'h8000);
                    write_reg(CFG_DERIV_GAIN, 16'h7FFF); write_reg(CFG_SCAN_EN, 16'd0);
                    write_reg(CFG_PAN_FOV, 16'h7FFF); write_reg(CFG_TILT_FOV, 16'd0);
                end
                2: begin
                    write_reg(CFG_PROP_GAIN, 16'h8000); write_reg(CFG_DERIV_GAIN, 16'h8000);
                    write_reg(CFG_LOST_LIMIT, 16'd0); write_reg(CFG_WAIT_LIMIT, 16'd0);
                    write_reg(CFG_SCAN_EN, 16'd1); write_reg(CFG_TILT_FOV, 16'h7FFF);
                end
                3: begin
                    write_reg(CFG_LOST_LIMIT, 16'd255); write_reg(CFG_WAIT_LIMIT, 16'd255);
                    write_reg(CFG_PAN_FOV, 16'd0);
                end
                4: for (int r = 0; r < 8; r++) write_reg(3'(r), 16'($urandom));
                default: begin
                    write_reg(CFG_PROP_GAIN, 16'd1638); write_reg(CFG_INTEG_GAIN, 16'd40);
                    write_reg(CFG_DERIV_GAIN, 16'd1); write_reg(CFG_LOST_LIMIT, 16'd6);
                    write_reg(CFG_WAIT_LIMIT, 16'd3); write_reg(CFG_PAN_FOV, 16'd2889);
                    write_reg(CFG_TILT_FOV, 16'd1622);
                end
            endcase
            queue_req(make_req(OP_START, 0, 0, 0, 0));
            add_episode(20);
            if (ph == 2) queue_req(make_req(OP_UNDEF_HI, 0, 0, MARK_SIZE, 0));
            add_episode(15);
            if (ph == 1) begin
                // Long receiver hold-off while requests keep coming.
                wait (pending_reqs.size() < 60);
                hold_off = 300;
            end
            wait_drained();
        end

        if (n_errors == 0) $display("testbench passed");
        else $display("testbench failed");
        $finish;
    end
endmodule
